FILE: design/slope_passability_mask_top_assert.svh
// Assertion macros used by the output buffer of the slope passability mask block.
`ifndef SLOPE_PASSABILITY_MASK_TOP_ASSERT_SVH
`define SLOPE_PASSABILITY_MASK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spm assertion failed");
`define SPM_ASSERT(lbl, prop) `SPM_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define SPM_ASSERT_CLK(lbl, clk, rst_n, prop)
`define SPM_ASSERT(lbl, prop)
`endif
`endif

FILE: design/spm_pkg.sv
// Shared types, constants and helpers of the slope passability mask block.
package spm_pkg;

    localparam int SPM_MAX_WIDTH = 1024;
    localparam int SPM_MAX_ROWS  = 4096;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 16;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_LIMIT  = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [10:0] RST_MAP_WIDTH    = 11'd1024;
    localparam logic [12:0] RST_MAP_HEIGHT   = 13'd1024;
    localparam logic [7:0]  RST_BORDER_WIDTH = 8'd1;
    localparam logic [15:0] RST_SLOPE_LIMIT  = 16'd512;

    typedef struct packed {
        logic [15:0] slope_limit;
        logic [7:0]  border_width;
        logic [12:0] map_height;
        logic [10:0] map_width;
    } t_cfg;

    typedef struct packed {
        logic step;
        logic pass;
    } t_step;

    typedef struct packed {
        logic        last_cell;
        logic [7:0]  direction_mask;
        logic [11:0] cell_y;
        logic [9:0]  cell_x;
    } t_result;

    function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
        int unsigned r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

FILE: design/spm_cfg_regs.sv
// Configuration register bank of the slope passability mask block.
module spm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output spm_pkg::t_cfg                    o_cfg,
    output spm_pkg::t_cfg                    o_cfg_next
);
    import spm_pkg::*;

    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:    n_cfg.map_width    = i_cfg_data[10:0];
                CFG_MAP_HEIGHT:   n_cfg.map_height   = i_cfg_data[12:0];
                CFG_BORDER_WIDTH: n_cfg.border_width = i_cfg_data[7:0];
                CFG_SLOPE_LIMIT:  n_cfg.slope_limit  = i_cfg_data[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width    <= RST_MAP_WIDTH;
            r_cfg.map_height   <= RST_MAP_HEIGHT;
            r_cfg.border_width <= RST_BORDER_WIDTH;
            r_cfg.slope_limit  <= RST_SLOPE_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg      = r_cfg;
    assign o_cfg_next = n_cfg;

endmodule

FILE: design/spm_slope.sv
// Height line buffer, 2x2 window and passability test of each cell.
module spm_slope #(
    parameter int MAX_WIDTH = spm_pkg::SPM_MAX_WIDTH,
    parameter int MAX_ROWS  = spm_pkg::SPM_MAX_ROWS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spm_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  logic            i_opcode,
    input  logic [15:0]     i_height,
    input  logic            i_clear,
    output spm_pkg::t_step  o_step
);
    import spm_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_ROWS + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [7:0]    b;

    logic [XW-1:0] r_in_x, n_in_x;
    logic [YW-1:0] r_in_y, n_in_y;
    logic [15:0]   r_left, r_upleft, r_up;
    logic [15:0]   line_mem [MAX_WIDTH];

    logic          in_map, sample, border_ok, slope_ok;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [15:0]   mx_a, mn_a, mx_b, mn_b, hi, lo, spread;

    assign w = WW'(clamp_u(32'(i_cfg.map_width), 32'd3, 32'(MAX_WIDTH)));
    assign h = HW'(clamp_u(32'(i_cfg.map_height), 32'd3, 32'(MAX_ROWS)));
    assign b = (i_cfg.border_width == 8'd0) ? 8'd1 : i_cfg.border_width;

    // Samples past the last row and flushes before it are dropped without a step.
    assign in_map = 32'(r_in_y) < 32'(h);
    assign sample = i_accept && (i_opcode == OP_SAMPLE) && in_map;

    // The window closes on the cell up and to the left of the incoming sample.
    assign cx = r_in_x - XW'(1);
    assign cy = r_in_y - YW'(1);
    assign border_ok = (r_in_x != '0) && (r_in_y != '0)
                    && (32'(cx) >= 32'(b)) && (32'(cx) + 32'(b) < 32'(w))
                    && (32'(cy) >= 32'(b)) && (32'(cy) + 32'(b) < 32'(h));

    assign mx_a   = (r_upleft > r_up) ? r_upleft : r_up;
    assign mn_a   = (r_upleft < r_up) ? r_upleft : r_up;
    assign mx_b   = (r_left > i_height) ? r_left : i_height;
    assign mn_b   = (r_left < i_height) ? r_left : i_height;
    assign hi     = (mx_a > mx_b) ? mx_a : mx_b;
    assign lo     = (mn_a < mn_b) ? mn_a : mn_b;
    assign spread = hi - lo;
    assign slope_ok = spread < i_cfg.slope_limit;

    assign o_step.step = sample || (i_accept && (i_opcode == OP_FLUSH) && !in_map);
    assign o_step.pass = sample && border_ok && slope_ok;

    always_comb begin
        n_in_x = r_in_x;
        n_in_y = r_in_y;
        if (sample) begin
            if (32'(r_in_x) + 32'd1 >= 32'(w)) begin
                n_in_x = '0;
                n_in_y = r_in_y + YW'(1);
            end else begin
                n_in_x = r_in_x + XW'(1);
            end
        end
        if (i_clear) begin
            n_in_x = '0;
            n_in_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_x   <= '0;
            r_in_y   <= '0;
            r_left   <= '0;
            r_upleft <= '0;
        end else begin
            r_in_x <= n_in_x;
            r_in_y <= n_in_y;
            if (sample) begin
                r_left   <= i_height;
                r_upleft <= r_up;
            end
        end
    end

    // The read port fetches the column of the next word, so the value above is ready.
    always_ff @(posedge i_clk) begin
        if (sample) begin
            line_mem[r_in_x] <= i_height;
        end
        r_up <= line_mem[n_in_x];
    end

endmodule

FILE: design/spm_mask.sv
// Passability ring, neighbour mask assembly and output cell counters.
module spm_mask #(
    parameter int MAX_WIDTH = spm_pkg::SPM_MAX_WIDTH,
    parameter int MAX_ROWS  = spm_pkg::SPM_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spm_pkg::t_cfg     i_cfg,
    input  spm_pkg::t_cfg     i_cfg_next,
    input  spm_pkg::t_step    i_step,
    output logic              o_valid,
    output spm_pkg::t_result  o_result,
    output logic              o_clear
);
    import spm_pkg::*;

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int OYW     = $clog2(MAX_ROWS);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_ROWS + 1);
    localparam int RA      = $clog2(2 * MAX_WIDTH + 1);
    localparam int RDEPTH  = 2 ** RA;
    localparam int LAG_MAX = 2 * MAX_WIDTH + 3;
    localparam int LW      = $clog2(LAG_MAX + 1);

    logic [WW-1:0]  w, w_next;
    logic [HW-1:0]  h;

    // Each entry holds the pass bits of one step and of the two steps before it.
    logic [2:0]     ring [RDEPTH];
    logic [RA-1:0]  r_wp, n_wp, dist_a, dist_b, addr_a, addr_b;
    logic           r_s1, r_s2;
    logic [2:0]     r_tap_a, r_tap_b;
    logic [LW-1:0]  r_lag, lag_inc, n_lag;
    logic [XW-1:0]  r_out_x, n_out_x;
    logic [OYW-1:0] r_out_y, n_out_y;
    logic           res_valid, last, self_pass;
    logic [7:0]     mask;

    assign w      = WW'(clamp_u(32'(i_cfg.map_width), 32'd3, 32'(MAX_WIDTH)));
    assign w_next = WW'(clamp_u(32'(i_cfg_next.map_width), 32'd3, 32'(MAX_WIDTH)));
    assign h      = HW'(clamp_u(32'(i_cfg.map_height), 32'd3, 32'(MAX_ROWS)));

    assign lag_inc   = (32'(r_lag) < 32'(LAG_MAX)) ? r_lag + LW'(1) : r_lag;
    assign res_valid = i_step.step && (32'(lag_inc) >= (32'(w) << 1) + 32'd3);
    assign last      = (32'(r_out_y) + 32'd1 >= 32'(h)) && (32'(r_out_x) + 32'd1 >= 32'(w));

    // Tap A is one row back from the newest pass bit, tap B two rows back.
    assign self_pass = r_tap_a[1];
    assign mask = self_pass ? {r_tap_b[2], r_tap_a[2], r_s2, r_s1,
                               i_step.pass, r_tap_a[0], r_tap_b[0], r_tap_b[1]} : 8'd0;

    assign o_valid                 = res_valid;
    assign o_clear                 = res_valid && last;
    assign o_result.cell_x         = 10'(r_out_x);
    assign o_result.cell_y         = 12'(r_out_y);
    assign o_result.direction_mask = mask;
    assign o_result.last_cell      = last;

    always_comb begin
        n_lag   = r_lag;
        n_out_x = r_out_x;
        n_out_y = r_out_y;
        if (i_step.step) begin
            n_lag = lag_inc;
        end
        if (res_valid) begin
            if (last) begin
                n_lag   = '0;
                n_out_x = '0;
                n_out_y = '0;
            end else if (32'(r_out_x) + 32'd1 >= 32'(w)) begin
                n_out_x = '0;
                n_out_y = r_out_y + OYW'(1);
            end else begin
                n_out_x = r_out_x + XW'(1);
            end
        end
    end

    assign n_wp   = i_step.step ? r_wp + RA'(1) : r_wp;
    assign dist_a = RA'(w_next);
    assign dist_b = dist_a << 1;
    assign addr_a = n_wp - dist_a;
    assign addr_b = n_wp - dist_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_s1    <= 1'b0;
            r_s2    <= 1'b0;
            r_lag   <= '0;
            r_out_x <= '0;
            r_out_y <= '0;
        end else begin
            r_wp    <= n_wp;
            r_lag   <= n_lag;
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            if (i_step.step) begin
                r_s1 <= i_step.pass;
                r_s2 <= r_s1;
            end
        end
    end

    // Both taps are fetched for the next word; they never hit the address being written.
    always_ff @(posedge i_clk) begin
        if (i_step.step) begin
            ring[r_wp] <= {r_s2, r_s1, i_step.pass};
        end
        r_tap_a <= ring[addr_a];
        r_tap_b <= ring[addr_b];
    end

endmodule

FILE: design/spm_out_buf.sv
// Two-entry output buffer that decouples the result stream from the input side.
`include "slope_passability_mask_top_assert.svh"
module spm_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spm_pkg::t_result  i_result,
    output logic              o_ready,
    output logic              o_valid,
    output spm_pkg::t_result  o_result,
    input  logic              i_pop_ready
);
    import spm_pkg::*;

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop      = r_main_valid && i_pop_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    `SPM_ASSERT(a_skid_needs_main, !r_skid_valid || r_main_valid)
    `SPM_ASSERT(a_no_push_when_full, !(i_push && r_skid_valid))
    `SPM_ASSERT(a_refill_from_skid, (r_main_valid && i_pop_ready && r_skid_valid) |=> r_main_valid)

endmodule

FILE: design/slope_passability_mask_top.sv
// Top level of the slope passability mask block.
// The block takes one stream word per clock: a height sample (tuser 0) or a flush (tuser 1),
// and its input side stays ready while the two-entry output buffer has room, so it sustains
// one word per cycle with back-to-back traffic. The mask of a cell leaves with the word that
// arrives 2*width+2 words after its own sample, registered in the output buffer. The rate
// is set by the two line memories, each written once and read ahead once per word: a height
// line of MAX_WIDTH x 16 bits and a pass ring of 2**clog2(2*MAX_WIDTH+1) x 3 bits read at two
// taps. Neither memory is cleared after reset; masks start only once a full window of new
// words has been seen, and after the mask marked last the next sample starts a new map.
module slope_passability_mask_top #(
    parameter int MAX_WIDTH = spm_pkg::SPM_MAX_WIDTH,
    parameter int MAX_ROWS  = spm_pkg::SPM_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // height_sample[15:0]
    input  logic [spm_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // opcode[0]
    input  logic [spm_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // cell_x[9:0], cell_y[21:10], direction_mask[29:22], zero[31:30]
    output logic [spm_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);
    import spm_pkg::*;

    t_cfg    cfg, cfg_next;
    t_step   step;
    t_result res, out_res;
    logic    accept, res_valid, clear, buf_ready;

    assign accept     = i_s_tvalid && buf_ready;
    assign o_s_tready = buf_ready;

    spm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_next  (cfg_next)
    );

    spm_slope #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_slope (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_opcode (i_s_tuser[0]),
        .i_height (i_s_tdata[15:0]),
        .i_clear  (clear),
        .o_step   (step)
    );

    spm_mask #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_mask (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cfg_next (cfg_next),
        .i_step     (step),
        .o_valid    (res_valid),
        .o_result   (res),
        .o_clear    (clear)
    );

    spm_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_result    (res),
        .o_ready     (buf_ready),
        .o_valid     (o_m_tvalid),
        .o_result    (out_res),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = {2'b00, out_res.direction_mask, out_res.cell_y, out_res.cell_x};
    assign o_m_tlast = out_res.last_cell;

endmodule

FILE: sim/slope_passability_mask_top_test.sv
// Self-checking stream testbench for the slope passability mask block.
`timescale 1ns / 100ps

module slope_passability_mask_top_test;
    import spm_pkg::*;

    localparam int unsigned RING_LEN = 2 * SPM_MAX_WIDTH + 3;
    localparam int SEND_IDLE [4] = '{0, 54, 0, 33};
    localparam int RECV_STALL [4] = '{0, 0, 54, 33};

    typedef struct packed {
        logic        op;
        logic [15:0] height;
        logic        typed;
        logic [9:0]  cell_x;
        logic [11:0] cell_y;
        logic [7:0]  mask;
        logic        last_cell;
    } t_dir_row;

    // A 3x3 map with a zero slope limit and a zero border: every mask is 0.
    localparam t_dir_row DIR_ROWS [19] = '{
        '{OP_SAMPLE, 16'h0000, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'hFFFF, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'h0000, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'hFFFF, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        // A flush before the map is complete is dropped.
        '{OP_FLUSH,  16'hFFFF, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'h8000, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'h7FFF, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'hAAAA, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'h5555, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_SAMPLE, 16'h0001, 1'b1, 10'd0, 12'd0, 8'h00, 1'b0},
        // A sample after the last cell of the map is in is dropped.
        '{OP_SAMPLE, 16'h1234, 1'b0, 10'd0, 12'd0, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd1, 12'd0, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd2, 12'd0, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd0, 12'd1, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd1, 12'd1, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd2, 12'd1, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd0, 12'd2, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd1, 12'd2, 8'h00, 1'b0},
        '{OP_FLUSH,  16'h0000, 1'b1, 10'd2, 12'd2, 8'h00, 1'b1}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [IN_TUSER_W-1:0]  i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    // Predictor state and its copy of the registers.
    logic [10:0]  reg_w = RST_MAP_WIDTH;
    logic [12:0]  reg_h = RST_MAP_HEIGHT;
    logic [7:0]   reg_b = RST_BORDER_WIDTH;
    logic [15:0]  reg_lim = RST_SLOPE_LIMIT;
    logic [15:0]  pred_line [SPM_MAX_WIDTH] = '{default: '0};
    bit           open_ring [RING_LEN] = '{default: 1'b0};
    int unsigned  ring_wp = 0;
    int unsigned  ring_fill = 0;
    logic [15:0]  win_left = '0;
    logic [15:0]  win_upleft = '0;
    int unsigned  pred_in_x = 0, pred_in_y = 0, pred_out_x = 0, pred_out_y = 0;
    bit           took_word = 1'b0;
    bit           map_done = 1'b0;

    t_result      pending_masks [$];
    t_result      seen_mask, due_mask;

    int           send_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           rx_hold = 0;
    int           fails = 0;
    int           words_used = 0;
    int           maps_done = 0;
    int           masks_checked = 0;
    int           open_masks = 0;

    bit           hgt_wild = 1'b0;
    logic [15:0]  hgt_base = '0;
    int unsigned  hgt_span = 0;

    slope_passability_mask_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned map_w_eff();
        int unsigned v;
        v = reg_w;
        if (v < 3) begin
            v = 3;
        end else if (v > SPM_MAX_WIDTH) begin
            v = SPM_MAX_WIDTH;
        end
        return v;
    endfunction

    function automatic int unsigned map_h_eff();
        int unsigned v;
        v = reg_h;
        if (v < 3) begin
            v = 3;
        end else if (v > SPM_MAX_ROWS) begin
            v = SPM_MAX_ROWS;
        end
        return v;
    endfunction

    function automatic bit ring_tap(input int unsigned age);
        return open_ring[(ring_wp + RING_LEN - age % RING_LEN) % RING_LEN];
    endfunction

    // Appends one expected mask word at the tail of the queue.
    function automatic void queue_due(input t_result r);
        pending_masks.insert(pending_masks.size(), r);
    endfunction

    // Advances the predictor by one accepted word; returns 1 when the word releases a mask.
    function automatic bit predict_mask(input logic op, input logic [15:0] hs,
                                        output t_result r);
        int unsigned w, h, b, cx, cy, idx, hi, lo;
        int unsigned quad [4];
        logic [15:0] up;
        bit          open_cell;
        bit          last;
        w = map_w_eff();
        h = map_h_eff();
        b = (reg_b == 0) ? 1 : reg_b;
        r = '0;
        took_word = 1'b0;
        open_cell = 1'b0;
        if (op == OP_SAMPLE) begin
            if (pred_in_y >= h) begin
                return 1'b0;
            end
            idx = pred_in_x % SPM_MAX_WIDTH;
            up = pred_line[idx];
            if (pred_in_x >= 1 && pred_in_y >= 1) begin
                cx = pred_in_x - 1;
                cy = pred_in_y - 1;
                if (cx >= b && cx + b < w && cy >= b && cy + b < h) begin
                    quad = '{win_upleft, up, win_left, hs};
                    hi = quad[0];
                    lo = quad[0];
                    foreach (quad[i]) begin
                        if (quad[i] > hi) hi = quad[i];
                        if (quad[i] < lo) lo = quad[i];
                    end
                    open_cell = (hi - lo < reg_lim);
                end
            end
            win_upleft = up;
            win_left = hs;
            pred_line[idx] = hs;
            pred_in_x++;
            if (pred_in_x >= w) begin
                pred_in_x = 0;
                pred_in_y++;
            end
        end else if (pred_in_y < h) begin
            return 1'b0;
        end
        took_word = 1'b1;
        words_used++;
        ring_wp = (ring_wp + 1) % RING_LEN;
        open_ring[ring_wp] = open_cell;
        if (ring_fill < RING_LEN) ring_fill++;
        if (ring_fill < 2 * w + 3) begin
            return 1'b0;
        end
        if (ring_tap(w + 1)) begin
            r.direction_mask = {ring_tap(2 * w + 2), ring_tap(w + 2), ring_tap(2), ring_tap(1),
                                ring_tap(0), ring_tap(w), ring_tap(2 * w), ring_tap(2 * w + 1)};
        end
        last = (pred_out_y + 1 >= h && pred_out_x + 1 >= w);
        r.cell_x = 10'(pred_out_x);
        r.cell_y = 12'(pred_out_y);
        r.last_cell = last;
        if (last) begin
            pred_in_x = 0;
            pred_in_y = 0;
            pred_out_x = 0;
            pred_out_y = 0;
            ring_fill = 0;
            map_done = 1'b1;
            maps_done++;
        end else begin
            pred_out_x++;
            if (pred_out_x >= w) begin
                pred_out_x = 0;
                pred_out_y++;
            end
        end
        return 1'b1;
    endfunction

    task automatic offer_word(input logic op, input logic [15:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= data;
        i_s_tuser <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_word(input logic op, input logic [15:0] data);
        t_result r;
        offer_word(op, data);
        if (predict_mask(op, data, r)) queue_due(r);
    endtask

    // Waits until every mask is out and the block has settled, then writes all registers.
    task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [15:0] b,
                             input logic [15:0] lim);
        logic [15:0]          vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        vals = '{w, h, b, lim};
        regs = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_BORDER_WIDTH, CFG_SLOPE_LIMIT};
        i_s_tvalid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            case (regs[i])
                CFG_MAP_WIDTH:    reg_w = vals[i][10:0];
                CFG_MAP_HEIGHT:   reg_h = vals[i][12:0];
                CFG_BORDER_WIDTH: reg_b = vals[i][7:0];
                default:          reg_lim = vals[i];
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Feeds one map through to its last mask, with stray words mixed in; stops early after
    // stop_after used words when that is nonzero.
    task automatic feed_map(input int unsigned stop_after);
        int unsigned taken;
        taken = 0;
        map_done = 1'b0;
        if (pred_in_x == 0 && pred_in_y == 0) begin
            hgt_wild = ($urandom_range(0, 3) == 0);
            hgt_base = 16'($urandom);
            hgt_span = $urandom_range(0, 1000);
        end
        while (!map_done && (stop_after == 0 || taken < stop_after)) begin
            if (pred_in_y < map_h_eff()) begin
                if ($urandom_range(0, 99) < 3) begin
                    send_word(OP_FLUSH, 16'($urandom));
                end else begin
                    send_word(OP_SAMPLE, hgt_wild ? 16'($urandom)
                                                  : 16'(hgt_base + $urandom_range(0, hgt_span)));
                end
            end else if ($urandom_range(0, 99) < 8) begin
                send_word(OP_SAMPLE, 16'($urandom));
            end else begin
                send_word(OP_FLUSH, 16'($urandom));
            end
            if (took_word) taken++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_mask.cell_x = o_m_tdata[9:0];
            seen_mask.cell_y = o_m_tdata[21:10];
            seen_mask.direction_mask = o_m_tdata[29:22];
            seen_mask.last_cell = o_m_tlast;
            if (pending_masks.size() == 0) begin
                $error("mask word with nothing expected: cell_x %0d cell_y %0d mask %02h",
                       seen_mask.cell_x, seen_mask.cell_y, seen_mask.direction_mask);
                fails++;
            end else begin
                due_mask = pending_masks.pop_front();
                masks_checked++;
                if (due_mask.direction_mask != 0) open_masks++;
                if (seen_mask.cell_x !== due_mask.cell_x) begin
                    $error("cell_x: expected %0d, got %0d", due_mask.cell_x, seen_mask.cell_x);
                    fails++;
                end
                if (seen_mask.cell_y !== due_mask.cell_y) begin
                    $error("cell_y: expected %0d, got %0d", due_mask.cell_y, seen_mask.cell_y);
                    fails++;
                end
                if (seen_mask.direction_mask !== due_mask.direction_mask) begin
                    $error("direction_mask: expected %02h, got %02h",
                           due_mask.direction_mask, seen_mask.direction_mask);
                    fails++;
                end
                if (seen_mask.last_cell !== due_mask.last_cell) begin
                    $error("last_cell: expected %0d, got %0d",
                           due_mask.last_cell, seen_mask.last_cell);
                    fails++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin
        t_result     r, typed_r;
        bit          has;
        int          ph, nb, start_words;
        logic [15:0] nw, nh, nl;
        int unsigned cut;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(16'd3, 16'd3, 16'd0, 16'd0);
        foreach (DIR_ROWS[i]) begin
            offer_word(DIR_ROWS[i].op, DIR_ROWS[i].height);
            has = predict_mask(DIR_ROWS[i].op, DIR_ROWS[i].height, r);
            if (DIR_ROWS[i].typed) begin
                typed_r.cell_x = DIR_ROWS[i].cell_x;
                typed_r.cell_y = DIR_ROWS[i].cell_y;
                typed_r.direction_mask = DIR_ROWS[i].mask;
                typed_r.last_cell = DIR_ROWS[i].last_cell;
                queue_due(typed_r);
            end else if (has) begin
                queue_due(r);
            end
        end

        for (ph = 0; ph < 8; ph++) begin
            send_idle_pct = SEND_IDLE[ph % 4];
            rx_stall_pct = RECV_STALL[ph % 4];
            // Oversized width, then oversized height: a stretch of words against the clamped
            // size, then the map shrinks partway in and runs to its last mask.
            if (ph == 0 || ph == 4) begin
                configure((ph == 0) ? 16'hFFFF : 16'd3, (ph == 0) ? 16'd3 : 16'hFFFF, 16'd1,
                          16'($urandom_range(100, 700)));
                feed_map(40);
                configure(16'($urandom_range(3, 6)), 16'($urandom_range(3, 6)), 16'd1,
                          16'($urandom_range(100, 700)));
                feed_map(0);
            end
            nw = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                             : 16'($urandom_range(3, 10));
            nh = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                             : 16'($urandom_range(3, 8));
            case ($urandom_range(0, 11))
                0, 1:    nb = 0;
                2, 3:    nb = $urandom_range(2, 3);
                4:       nb = 255;
                default: nb = 1;
            endcase
            case ($urandom_range(0, 9))
                0:       nl = 16'h0000;
                1:       nl = 16'hFFFF;
                default: nl = 16'($urandom_range(1, 900));
            endcase
            if (ph == 1) begin
                nl = 16'hFFFF;
                nb = 1;
            end
            configure(nw, nh, 16'(nb), nl);
            if (ph == 5) rx_hold = 300;
            if (ph == 2) begin
                // Stop partway into the second row, let the block drain, then resize the map.
                cut = map_w_eff() + $urandom_range(1, map_w_eff());
                feed_map(cut);
                configure(16'($urandom_range(3, map_w_eff())), 16'($urandom_range(3, 8)),
                          16'(nb), 16'($urandom_range(1, 900)));
                feed_map(0);
            end
            start_words = words_used;
            while (words_used - start_words < 30) feed_map(0);
        end

        i_s_tvalid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d used words over %0d maps; %0d masks checked, %0d with open neighbors.",
                 words_used, maps_done, masks_checked, open_masks);
        $display("Covered small and oversized sizes, resizing within a map, zero and full slope");
        $display("limits, idle senders, stalled receivers and a long receiver hold.");
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
